/* hdl/dipte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipte_pkg
// Shared types and constants for the pattern trigger engine.
// ----------------------------------------------------------------------------
package dipte_pkg;

  localparam int PIN_W = 24;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_FIRE   = 3'd4,
    ACT_UPDATE = 3'd5,
    ACT_ENABLE = 3'd6,
    ACT_POP    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_QFULL     = 3'd2,
    ST_QEMPTY    = 3'd3,
    ST_TFULL     = 3'd4,
    ST_OVERLAP   = 3'd5,
    ST_RSVD6     = 3'd6,
    ST_RSVD7     = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE,
    S_OUT
  } state_t;

  localparam logic [1:0] REG_IN  = 2'd0;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic shift_busy;
    logic needs_scan;
    logic needs_shift;
  } stat_t;

  function automatic logic [PIN_W-1:0] blocks_to_mask(input logic [3:0] sel);
    blocks_to_mask = (sel[0] ? 24'h0000ff : 24'h0) | (sel[1] ? 24'h00ff00 : 24'h0) |
                     (sel[2] ? 24'h0f0000 : 24'h0) | (sel[3] ? 24'hf00000 : 24'h0);
  endfunction

endpackage

/* hdl/dipte_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipte_ctrl
// Sequencer: accept request, step the datapath, present the result.
// ----------------------------------------------------------------------------
module dipte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dipte_pkg::cmd_t cmd,
  input  dipte_pkg::stat_t stat
);
  import dipte_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (stat.needs_scan) begin
            state_next = S_SCAN;
          end else if (stat.needs_shift) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (!stat.scan_busy) state_next = S_DONE;
      end
      S_SHIFT: begin
        cmd.step = 1'b1;
        if (!stat.shift_busy) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* hdl/dipte_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipte_dp
// Trigger table, event queue, output latch; scans one entry per cycle.
// ----------------------------------------------------------------------------
module dipte_dp #(
  parameter int MAX_TRIGGERS = 16,
  parameter int QUEUE_DEPTH  = 32,
  parameter int ID_WIDTH     = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [0:0]                  cfg_index,
  input  logic [3:0]                  cfg_data,
  input  logic [2:0]                  action,
  input  logic [dipte_pkg::PIN_W-1:0] pins_in,
  input  logic [15:0]                 trigger_id,
  input  logic [dipte_pkg::PIN_W-1:0] match_mask,
  input  logic [dipte_pkg::PIN_W-1:0] match_bits,
  input  logic                        toggle_mode,
  input  logic                        zero_outputs,
  input  logic                        enable_value,
  input  dipte_pkg::cmd_t             cmd,
  output dipte_pkg::stat_t            stat,
  output logic [2:0]                  status,
  output logic [dipte_pkg::PIN_W-1:0] pin_write_mask,
  output logic [dipte_pkg::PIN_W-1:0] pin_write_bits,
  output logic [15:0]                 popped_id,
  output logic                        popped_valid,
  output logic [4:0]                  fired_count,
  output logic [4:0]                  dropped_count,
  output logic [5:0]                  queue_level
);
  import dipte_pkg::*;

  localparam int TI = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
  localparam int TC = $clog2(MAX_TRIGGERS + 1);
  localparam int QI = $clog2(QUEUE_DEPTH);
  localparam int QC = $clog2(QUEUE_DEPTH + 1);

  logic [3:0] in_sel, out_sel;
  logic [ID_WIDTH-1:0] ids [MAX_TRIGGERS];
  logic [PIN_W-1:0]    msk [MAX_TRIGGERS];
  logic [PIN_W-1:0]    pat [MAX_TRIGGERS];
  logic                tog [MAX_TRIGGERS];
  logic [PIN_W-1:0]    lst [MAX_TRIGGERS];
  logic [TC-1:0]       count;
  logic [ID_WIDTH-1:0] queue [QUEUE_DEPTH];
  logic [QI-1:0]       head, tail;
  logic [QC-1:0]       fill;
  logic [PIN_W-1:0]    latch;
  logic                armed;

  logic [2:0]          act;
  logic [PIN_W-1:0]    spins;
  logic [TC-1:0]       idx;
  logic                busy_scan, busy_shift;
  logic [4:0]          fired, dropped;

  logic [ID_WIDTH-1:0] in_id;
  logic                in_hit;
  logic [TI-1:0]       in_pos;
  logic                overlap;

  assign in_id   = ID_WIDTH'(trigger_id);
  assign overlap = |(in_sel & out_sel);

  // parallel id lookup over the table
  always_comb begin
    in_hit = 1'b0;
    in_pos = '0;
    for (int i = MAX_TRIGGERS - 1; i >= 0; i--) begin
      if ((TC'(i) < count) && ids[i] == in_id) begin
        in_hit = 1'b1;
        in_pos = TI'(i);
      end
    end
  end

  logic [TI-1:0]    cur;
  logic [PIN_W-1:0] mv, flip;
  logic             match;
  assign cur   = idx[TI-1:0];
  assign mv    = spins & msk[cur];
  assign flip  = ~pat[cur] & msk[cur];
  assign match = (mv != lst[cur]) && ((mv == pat[cur]) || (tog[cur] && mv == flip));

  assign stat.scan_busy   = busy_scan;
  assign stat.shift_busy  = busy_shift;
  assign stat.needs_scan  = (action == ACT_TICK) && !overlap && (count != '0);
  assign stat.needs_shift = (action == ACT_REMOVE) && in_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sel <= 4'd1;
      out_sel <= 4'd2;
      count <= '0;
      head <= '0;
      tail <= '0;
      fill <= '0;
      latch <= '0;
      armed <= 1'b0;
      busy_scan <= 1'b0;
      busy_shift <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_IN[0]) in_sel <= cfg_data;
        else out_sel <= cfg_data;
      end
      if (cmd.start) begin
        act <= action;
        spins <= pins_in & blocks_to_mask(in_sel);
        fired <= '0;
        dropped <= '0;
        status <= ST_OK;
        pin_write_mask <= '0;
        pin_write_bits <= '0;
        popped_id <= '0;
        popped_valid <= 1'b0;
        unique case (action_t'(action))
          ACT_TICK: begin
            if (overlap) begin
              status <= ST_OVERLAP;
            end else begin
              if (armed) begin
                pin_write_mask <= blocks_to_mask(out_sel);
                pin_write_bits <= latch & blocks_to_mask(out_sel);
                armed <= 1'b0;
              end
              idx <= count - 1'b1;
              busy_scan <= (count != '0);
            end
          end
          ACT_ADD: begin
            if (in_hit) begin
              status <= ST_DUP;
            end else if (count >= TC'(MAX_TRIGGERS)) begin
              status <= ST_TFULL;
            end else begin
              ids[count[TI-1:0]] <= in_id;
              msk[count[TI-1:0]] <= match_mask;
              pat[count[TI-1:0]] <= match_bits;
              tog[count[TI-1:0]] <= toggle_mode;
              lst[count[TI-1:0]] <= '0;
              count <= count + 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (in_hit) begin
              idx <= TC'(in_pos);
              busy_shift <= 1'b1;
            end
          end
          ACT_CLEAR: count <= '0;
          ACT_FIRE: begin
            if (in_hit) begin
              if (fill >= QC'(QUEUE_DEPTH)) begin
                status <= ST_QFULL;
              end else begin
                queue[tail] <= in_id;
                tail <= (tail == QI'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
                fill <= fill + 1'b1;
              end
            end
          end
          ACT_UPDATE: begin
            if (zero_outputs) latch <= '0;
            else latch <= (latch & ~match_mask) | (match_mask & match_bits);
          end
          ACT_ENABLE: armed <= enable_value;
          ACT_POP: begin
            if (fill == '0) begin
              status <= ST_QEMPTY;
            end else begin
              popped_id <= 16'(queue[head]);
              popped_valid <= 1'b1;
              head <= (head == QI'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
              fill <= fill - 1'b1;
            end
          end
          default: ;
        endcase
      end else if (cmd.step && busy_scan) begin
        lst[cur] <= mv;
        if (match) begin
          if (fired != 5'd31) fired <= fired + 1'b1;
          if (fill >= QC'(QUEUE_DEPTH)) begin
            if (dropped != 5'd31) dropped <= dropped + 1'b1;
          end else begin
            queue[tail] <= ids[cur];
            tail <= (tail == QI'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            fill <= fill + 1'b1;
          end
        end
        if (idx == '0) busy_scan <= 1'b0;
        else idx <= idx - 1'b1;
      end else if (cmd.step && busy_shift) begin
        if (idx + 1'b1 < count) begin
          ids[cur] <= ids[TI'(idx + 1'b1)];
          msk[cur] <= msk[TI'(idx + 1'b1)];
          pat[cur] <= pat[TI'(idx + 1'b1)];
          tog[cur] <= tog[TI'(idx + 1'b1)];
          lst[cur] <= lst[TI'(idx + 1'b1)];
          idx <= idx + 1'b1;
        end else begin
          busy_shift <= 1'b0;
          count <= count - 1'b1;
        end
      end else if (cmd.finish) begin
        fired_count <= fired;
        dropped_count <= dropped;
        if (act == ACT_TICK && dropped != '0) status <= ST_QFULL;
        queue_level <= (fill > QC'(63)) ? 6'd63 : 6'(fill);
      end
    end
  end
endmodule

/* hdl/digital_input_pattern_trigger_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digital_input_pattern_trigger_engine_top
// Pattern trigger engine over a 24-bit pin bank.
// ----------------------------------------------------------------------------
// Use: send one request on s_axis; one result comes back on m_axis.
// Config channel writes register 0 (input groups) or 1 (output groups);
// the user must write only while the block is idle (the block itself does
// not enforce this). A tick scans one trigger entry per cycle, and skips
// the scan with an empty table or on overlap; a remove shifts the later
// table entries down for the table compaction; other requests go straight
// to the result.
// One request at a time; s_axis_tready is low until the result is taken.
// A stalled m_axis holds the result and blocks new requests.
// Reset clears the table, queue, output latch and arm flag; register 0
// returns to 1 and register 1 to 2.
// ----------------------------------------------------------------------------
module digital_input_pattern_trigger_engine_top #(
  parameter int MAX_TRIGGERS = 16,
  parameter int QUEUE_DEPTH  = 32,
  parameter int ID_WIDTH     = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [3:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[2:0], pins_in[26:3], trigger_id[42:27], match_mask[66:43],
  // match_bits[90:67], toggle_mode[91], zero_outputs[92], enable_value[93]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], pin_write_mask[26:3], pin_write_bits[50:27],
  // popped_id[66:51], popped_valid[67], fired_count[72:68],
  // dropped_count[77:73], queue_level[83:78]
  output logic [87:0]  m_axis_tdata
);
  import dipte_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [2:0]       status;
  logic [PIN_W-1:0] wm, wb;
  logic [15:0]      pid;
  logic             pv;
  logic [4:0]       fc, dc;
  logic [5:0]       ql;

  assign cfg_ready = 1'b1;

  dipte_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd, .stat
  );

  dipte_dp #(.MAX_TRIGGERS(MAX_TRIGGERS), .QUEUE_DEPTH(QUEUE_DEPTH),
             .ID_WIDTH(ID_WIDTH)) u_dp (
    .clk, .rst,
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (s_axis_tdata[2:0]),
    .pins_in     (s_axis_tdata[26:3]),
    .trigger_id  (s_axis_tdata[42:27]),
    .match_mask  (s_axis_tdata[66:43]),
    .match_bits  (s_axis_tdata[90:67]),
    .toggle_mode (s_axis_tdata[91]),
    .zero_outputs(s_axis_tdata[92]),
    .enable_value(s_axis_tdata[93]),
    .cmd, .stat,
    .status, .pin_write_mask(wm), .pin_write_bits(wb),
    .popped_id(pid), .popped_valid(pv), .fired_count(fc),
    .dropped_count(dc), .queue_level(ql)
  );

  assign m_axis_tdata = {4'd0, ql, dc, fc, pv, pid, wb, wm, status};
endmodule
